### rtl/ffl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_pkg
// Shared types and codes for the first-fit free list.
// ----------------------------------------------------------------------------
package ffl_pkg;

	localparam int OFFSET_W  = 31;
	localparam int SIZE_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 48;  // offset + size, padded to bytes
	localparam int M_TDATA_W = 32;  // offset, padded to bytes

	// request kinds (s_tuser)
	localparam logic FUNC_PUT = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	// result status codes (m_tuser)
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [SIZE_W-1:0]   size;
		logic [OFFSET_W-1:0] offset;
	} ffl_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;   // latch request beat, restart scan pointer
		logic do_put;     // append or flag full
		logic do_scan;    // first-fit search step
		logic do_shift;   // close-the-gap step
		logic load_out;   // move result into output register
	} ffl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_hit;
		logic scan_miss;
		logic shift_done;
		logic out_free;
	} ffl_stat_t;

endpackage

### rtl/first_fit_free_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list
// Ordered free-block list with append and first-fit remove.
// ----------------------------------------------------------------------------
// A put beat (s_tuser = 0) appends {offset, size} at the tail of the list, or
// reports status 2 when all LIST_DEPTH slots are used. A get beat
// (s_tuser = 1) walks the list from the head and removes the first block
// whose size is at least the requested size, returning its offset with
// status 0; the blocks behind it move up one slot so list order holds.
// A get with no fit returns status 1 and offset zero. Every request gives
// exactly one result beat. Entries live in a single-port-write, registered-
// read memory, one entry per cycle. After the accepting edge a put runs
// through the put and done states; a get runs through the scan and, on a
// hit, the shift before the done state, and reads every entry in the list
// (the scan up to the hit, then the entries behind it that are moved). The
// sequencer is back in idle, and accepts the next request, in the cycle
// after the result is loaded; a full output register holds it in the done
// state until m_tready frees the register. The next request is taken while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module first_fit_free_list #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ffl_pkg::S_TDATA_W-1:0] s_tdata,   // [30:0] block_offset, [46:31] block_size
	input  logic                          s_tuser,   // [0] func: 0 put, 1 get
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ffl_pkg::M_TDATA_W-1:0] m_tdata,   // [30:0] found_offset
	output logic [ffl_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);

	ffl_pkg::ffl_cmd_t  cmd;
	ffl_pkg::ffl_stat_t stat;

	// sequencer: one request at a time
	ffl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// entry store, scan compare and output register
	ffl_dpath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### rtl/ffl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_ctrl
// Sequencer: accept, put / scan / shift, then hand off the result beat.
// ----------------------------------------------------------------------------
module ffl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_func,
	output logic             s_tready,
	output ffl_pkg::ffl_cmd_t cmd,
	input  ffl_pkg::ffl_stat_t stat
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PUT   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d = (s_func == ffl_pkg::FUNC_PUT) ? S_PUT : S_SCAN;
				end
			end
			S_PUT: begin
				cmd.do_put = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN: begin
				cmd.do_scan = 1'b1;
				if (stat.scan_hit) begin
					state_d = S_SHIFT;
				end else if (stat.scan_miss) begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				cmd.do_shift = 1'b1;
				if (stat.shift_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/ffl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_dpath
// Entry memory, fill count, scan pointer, compare and result registers.
// ----------------------------------------------------------------------------
module ffl_dpath #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ffl_pkg::ffl_cmd_t                     cmd,
	output ffl_pkg::ffl_stat_t                    stat,
	input  logic [ffl_pkg::S_TDATA_W-1:0]         s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [ffl_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic [ffl_pkg::STATUS_W-1:0]          m_tuser
);

	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

	ffl_pkg::ffl_entry_t mem [LIST_DEPTH];

	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 ptr_q;
	ffl_pkg::ffl_entry_t              req_q;
	ffl_pkg::ffl_entry_t              rd_data_q;
	logic [IDX_W-1:0]                 rd_idx_q;
	logic                             rd_vld_q;
	logic [ffl_pkg::STATUS_W-1:0]     res_status_q;
	logic [ffl_pkg::OFFSET_W-1:0]     res_offset_q;
	logic                             out_vld_q;
	logic [ffl_pkg::STATUS_W-1:0]     out_status_q;
	logic [ffl_pkg::OFFSET_W-1:0]     out_offset_q;

	logic                             rd_go;
	logic                             wr_en;
	logic [IDX_W-1:0]                 wr_addr;
	ffl_pkg::ffl_entry_t              wr_data;
	logic                             full;

	assign full  = (count_q == DEPTH_C);
	assign rd_go = (cmd.do_scan || cmd.do_shift) && (ptr_q < count_q);

	assign stat.scan_hit   = rd_vld_q && (rd_data_q.size >= req_q.size);
	assign stat.scan_miss  = !rd_vld_q && (ptr_q >= count_q);
	assign stat.shift_done = !rd_vld_q;
	assign stat.out_free   = !out_vld_q || m_tready;

	// put appends at the tail; shift moves the fetched entry up one slot
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = req_q;
		if (cmd.do_put && !full) begin
			wr_en = 1'b1;
		end else if (cmd.do_shift && rd_vld_q) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_q - IDX_W'(1);
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_go) begin
			rd_data_q <= mem[ptr_q[IDX_W-1:0]];
			rd_idx_q  <= ptr_q[IDX_W-1:0];
		end
		if (cmd.load_req) begin
			req_q.offset <= s_tdata[ffl_pkg::OFFSET_W-1:0];
			req_q.size   <= s_tdata[ffl_pkg::OFFSET_W +: ffl_pkg::SIZE_W];
		end
		if (cmd.do_put) begin
			res_status_q <= full ? ffl_pkg::ST_FULL : ffl_pkg::ST_DONE;
			res_offset_q <= '0;
		end else if (cmd.do_scan && stat.scan_hit) begin
			res_status_q <= ffl_pkg::ST_DONE;
			res_offset_q <= rd_data_q.offset;
		end else if (cmd.do_scan && stat.scan_miss) begin
			res_status_q <= ffl_pkg::ST_NOT_FOUND;
			res_offset_q <= '0;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_offset_q <= res_offset_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			rd_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				ptr_q    <= '0;
				rd_vld_q <= 1'b0;
			end else if (cmd.do_scan || cmd.do_shift) begin
				rd_vld_q <= rd_go;
				if (rd_go) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
			end
			if (cmd.do_put && !full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.do_shift && stat.shift_done) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(ffl_pkg::M_TDATA_W - ffl_pkg::OFFSET_W){1'b0}}, out_offset_q};

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the first-fit free list.
// ----------------------------------------------------------------------------
// Request beats are sent through named test tasks. Each accepted request is
// run through a free-list predictor kept in this bench, which appends or
// removes blocks exactly as the block should. The outcome is queued as the
// result the block owes us. A checker pops the oldest owed result on every
// result beat and compares status and found offset. A directed part covers
// the empty list, a full list with overflow, extreme offsets and sizes, and
// first-fit order. Random traffic follows, with put-heavy, balanced and
// get-heavy mixes so the list keeps moving between full and empty. Both
// sides stall at random, and the balanced mix runs with no stalls at all.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FREE_DEPTH  = 16;
	localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side

	typedef struct packed {
		logic [ffl_pkg::STATUS_W-1:0] status;
		logic [ffl_pkg::OFFSET_W-1:0] offset;
	} alloc_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [ffl_pkg::S_TDATA_W-1:0] s_tdata;
	logic                          s_tuser;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [ffl_pkg::M_TDATA_W-1:0] m_tdata;
	logic [ffl_pkg::STATUS_W-1:0]  m_tuser;

	// predictor copy of the free list
	logic [ffl_pkg::OFFSET_W-1:0] free_off [FREE_DEPTH];
	logic [ffl_pkg::SIZE_W-1:0]   free_sz  [FREE_DEPTH];
	int                           free_cnt;

	alloc_result_t owed_results[$];  // results the block still owes, oldest first
	int            errors = 0;
	int            quiet_cycles = 0;
	logic          stalls_on;        // random stalls enabled on both sides

	first_fit_free_list #(
		.LIST_DEPTH(FREE_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Apply one request to the predicted list and return the result it owes.
	function automatic alloc_result_t free_list_apply(input logic func,
		input logic [ffl_pkg::OFFSET_W-1:0] offs,
		input logic [ffl_pkg::SIZE_W-1:0] size);
		alloc_result_t r;
		int            hit;
		r.status = ffl_pkg::ST_DONE;
		r.offset = '0;
		hit      = -1;
		if (func == ffl_pkg::FUNC_PUT) begin
			if (free_cnt >= FREE_DEPTH) begin
				r.status = ffl_pkg::ST_FULL;   // dropped, list untouched
			end else begin
				free_off[free_cnt] = offs;
				free_sz[free_cnt]  = size;
				free_cnt++;
			end
		end else begin
			for (int k = 0; k < free_cnt; k++) begin
				if (hit < 0 && free_sz[k] >= size)
					hit = k;
			end
			if (hit < 0) begin
				r.status = ffl_pkg::ST_NOT_FOUND;
			end else begin
				r.offset = free_off[hit];
				// whole block goes, the ones behind it move up a slot
				for (int k = hit; k < free_cnt - 1; k++) begin
					free_off[k] = free_off[k + 1];
					free_sz[k]  = free_sz[k + 1];
				end
				free_cnt--;
			end
		end
		return r;
	endfunction

	// Send one request beat; tvalid stays up after the handshake so that
	// back-to-back beats never drop it. Whoever pauses next lowers it.
	task automatic send_req(input logic func, input logic [ffl_pkg::OFFSET_W-1:0] offs,
		input logic [ffl_pkg::SIZE_W-1:0] size);
		while (stalls_on && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {1'b0, size, offs};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		owed_results.push_back(free_list_apply(func, offs, size));
	endtask

	// Stop sending and wait until every owed result has come back.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list();
		send_req(ffl_pkg::FUNC_GET, '0, '0);  // size zero still misses on empty list
		send_req(ffl_pkg::FUNC_GET, '1, '1);
	endtask

	// Fill every slot, then overflow twice. Slot 1 carries the top offset and
	// size zero, slot 5 the largest size.
	task automatic test_fill_to_full();
		logic [ffl_pkg::OFFSET_W-1:0] offs;
		logic [ffl_pkg::SIZE_W-1:0]   size;
		for (int k = 0; k < FREE_DEPTH; k++) begin
			offs = ffl_pkg::OFFSET_W'(k * 32'h0800_1001);
			size = ffl_pkg::SIZE_W'(k * 16'h0123);
			if (k == 1) begin
				offs = '1;
				size = '0;
			end
			if (k == 5)
				size = '1;
			send_req(ffl_pkg::FUNC_PUT, offs, size);
		end
		send_req(ffl_pkg::FUNC_PUT, 31'h2AAA_AAAA, 16'h5555);
		send_req(ffl_pkg::FUNC_PUT, 31'h5555_5555, 16'hAAAA);
	endtask

	task automatic test_first_fit_order();
		send_req(ffl_pkg::FUNC_GET, '0, '1);        // hit in the middle of the list
		send_req(ffl_pkg::FUNC_GET, '1, '1);        // nothing that large is left
		send_req(ffl_pkg::FUNC_GET, '0, '0);        // size zero takes the head only
		send_req(ffl_pkg::FUNC_GET, '0, 16'h0500);  // skips smaller blocks near the head
	endtask

	task automatic test_random_traffic(input int n_items, input int put_pct);
		logic                         func;
		logic [ffl_pkg::OFFSET_W-1:0] offs;
		logic [ffl_pkg::SIZE_W-1:0]   size;
		int                           pick;
		for (int i = 0; i < n_items; i++) begin
			func = ($urandom_range(99) < put_pct) ? ffl_pkg::FUNC_PUT : ffl_pkg::FUNC_GET;
			offs = ffl_pkg::OFFSET_W'($urandom);
			case ($urandom_range(15))
				0: offs = '0;
				1: offs = '1;
				default: ;
			endcase
			size = ffl_pkg::SIZE_W'($urandom);
			if (func == ffl_pkg::FUNC_GET && free_cnt > 0) begin
				// aim at stored sizes so hits land all over the list
				pick = $urandom_range(free_cnt - 1);
				case ($urandom_range(5))
					0, 1: size = free_sz[pick];
					2: size = free_sz[pick] + 16'd1;
					3: size = ffl_pkg::SIZE_W'($urandom_range(3));
					default: ;
				endcase
			end else if ($urandom_range(15) == 0) begin
				size = $urandom_range(1) ? '1 : '0;
			end
			send_req(func, offs, size);
		end
	endtask

	// Result side: random backpressure, none while stalls are off.
	always @(posedge clk)
		m_tready <= !stalls_on || ($urandom_range(99) >= 8);

	// Compare every result beat with the oldest owed result.
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result beat with nothing owed: status %0d offset %h",
						m_tuser, m_tdata[ffl_pkg::OFFSET_W-1:0]);
			end else begin
				want = owed_results.pop_front();
				if (m_tuser !== want.status) begin
					errors++;
					if (errors <= 10)
						$display("status mismatch: exp %0d got %0d", want.status, m_tuser);
				end
				if (m_tdata[ffl_pkg::OFFSET_W-1:0] !== want.offset) begin
					errors++;
					if (errors <= 10)
						$display("found_offset mismatch: exp %h got %h", want.offset,
							m_tdata[ffl_pkg::OFFSET_W-1:0]);
				end
			end
		end
	end

	// Watchdog: too long with no beat on either side means the block hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		free_cnt     = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= ffl_pkg::FUNC_PUT;
		s_tdata   <= '0;
		stalls_on <= 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_to_full();
		test_first_fit_order();
		test_random_traffic(450, 70);
		hold_until_drained();              // sender holds off with nothing in flight
		stalls_on <= 1'b0;
		test_random_traffic(450, 50);
		stalls_on <= 1'b1;
		test_random_traffic(450, 30);
		hold_until_drained();
		repeat (FREE_DEPTH + 8) @(posedge clk);

		if (errors == 0 && owed_results.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
